// ===== sv/lde_pkg.sv =====
// Shared types, codes and constants for the line draw engine.
package lde_pkg;

  // Field and register widths
  localparam int COORD_W  = 12;
  localparam int DIM_W    = 13;
  localparam int COLOR_W  = 32;
  localparam int ADDR_W   = 2 * DIM_W;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  // Default frame store size in pixels
  localparam int STORE_PIXELS_DEF = 4096;

  // Register reset values
  localparam logic [DIM_W-1:0] ROW_WIDTH_RST = 13'd64;
  localparam logic [DIM_W-1:0] ROW_COUNT_RST = 13'd64;

  // Register index, taken from paddr bit 2
  localparam logic REG_ROW_WIDTH = 1'b0;
  localparam logic REG_ROW_COUNT = 1'b1;

  // Result status codes
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  // Command modes
  typedef enum logic [1:0] {
    MODE_WRITE = 2'd0,
    MODE_LINE  = 2'd1,
    MODE_POLY  = 2'd2,
    MODE_READ  = 2'd3
  } mode_t;

  // Input transaction
  typedef struct packed {
    mode_t              mode;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] y_end;
    logic [COLOR_W-1:0] color;
  } cmd_t;

  // Result transaction
  typedef struct packed {
    logic               status;
    logic [COLOR_W-1:0] pixel_value;
  } result_t;

  // Line endpoints handed to the stepper
  typedef struct packed {
    logic [COORD_W-1:0] x0;
    logic [COORD_W-1:0] y0;
    logic [COORD_W-1:0] x1;
    logic [COORD_W-1:0] y1;
  } line_t;

  // Stepper status and pixel output
  typedef struct packed {
    logic               active;
    logic               valid;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } step_out_t;

  // Pixel access request
  typedef struct packed {
    logic               valid;
    logic               wr;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
  } pix_req_t;

  // Pixel unit status
  typedef struct packed {
    logic               busy;
    logic [COLOR_W-1:0] rd_value;
  } pu_stat_t;

endpackage

// ===== sv/lde_ram.sv =====
// Generic single-port RAM with registered read data.
module lde_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write or read one word per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/lde_stepper.sv =====
// Line stepper: orders a line and emits one pixel coordinate per cycle.
module lde_stepper (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lde_pkg::line_t    pts,
  output lde_pkg::step_out_t step_out
);

  localparam int CW = lde_pkg::COORD_W;

  typedef enum logic [1:0] {ST_IDLE, ST_SETUP, ST_RUN} st_t;

  st_t                    state_r, state_nxt;
  lde_pkg::line_t         pts_r, pts_nxt;
  logic                   xmaj_r, xmaj_nxt;
  logic [CW-1:0]          m_r, m_nxt;
  logic [CW-1:0]          q_r, q_nxt;
  logic [CW-1:0]          n_r, n_nxt;
  logic [CW-1:0]          den_r, den_nxt;
  logic signed [CW:0]     d_r, d_nxt;
  logic signed [CW+1:0]   r_r, r_nxt;

  logic [CW-1:0]          adx, ady, major_s, minor_s, minor_e;
  logic                   xmaj, swap;
  logic signed [CW+1:0]   r_sum, den_s;

  // Order the endpoints and pick the major axis
  always_comb begin
    adx = (pts_r.x1 > pts_r.x0) ? pts_r.x1 - pts_r.x0 : pts_r.x0 - pts_r.x1;
    ady = (pts_r.y1 > pts_r.y0) ? pts_r.y1 - pts_r.y0 : pts_r.y0 - pts_r.y1;
    xmaj = adx > ady;
    swap = xmaj ? (pts_r.x0 > pts_r.x1) : (pts_r.y0 > pts_r.y1);
    major_s = xmaj ? (swap ? pts_r.x1 : pts_r.x0) : (swap ? pts_r.y1 : pts_r.y0);
    minor_s = xmaj ? (swap ? pts_r.y1 : pts_r.y0) : (swap ? pts_r.x1 : pts_r.x0);
    minor_e = xmaj ? (swap ? pts_r.y0 : pts_r.y1) : (swap ? pts_r.x0 : pts_r.x1);
  end

  // Advance the remainder; at most one correction per step
  assign r_sum = r_r + {d_r[CW], d_r};
  assign den_s = $signed({2'b00, den_r});

  always_comb begin
    state_nxt = state_r;
    pts_nxt   = pts_r;
    xmaj_nxt  = xmaj_r;
    m_nxt     = m_r;
    q_nxt     = q_r;
    n_nxt     = n_r;
    den_nxt   = den_r;
    d_nxt     = d_r;
    r_nxt     = r_r;
    unique case (state_r)
      ST_IDLE: begin
        if (load) begin
          pts_nxt   = pts;
          state_nxt = ST_SETUP;
        end
      end
      ST_SETUP: begin
        xmaj_nxt  = xmaj;
        m_nxt     = major_s;
        q_nxt     = minor_s;
        n_nxt     = xmaj ? adx : ady;
        den_nxt   = xmaj ? adx : ady;
        d_nxt     = $signed({1'b0, minor_e}) - $signed({1'b0, minor_s});
        r_nxt     = '0;
        state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (n_r == '0) begin
          state_nxt = ST_IDLE;
        end else begin
          m_nxt = m_r + 1'b1;
          n_nxt = n_r - 1'b1;
          if (r_sum >= den_s) begin
            r_nxt = r_sum - den_s;
            q_nxt = q_r + 1'b1;
          end else if (r_sum < 0) begin
            r_nxt = r_sum + den_s;
            q_nxt = q_r - 1'b1;
          end else begin
            r_nxt = r_sum;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pts_r  <= pts_nxt;
    xmaj_r <= xmaj_nxt;
    m_r    <= m_nxt;
    q_r    <= q_nxt;
    n_r    <= n_nxt;
    den_r  <= den_nxt;
    d_r    <= d_nxt;
    r_r    <= r_nxt;
  end

  // Map major/minor back to x/y
  always_comb begin
    step_out.active = (state_r != ST_IDLE);
    step_out.valid  = (state_r == ST_RUN) && (n_r != '0);
    step_out.x      = xmaj_r ? m_r : q_r;
    step_out.y      = xmaj_r ? q_r : m_r;
  end

endmodule

// ===== sv/lde_pixel_unit.sv =====
// Pixel unit: address pipeline, bounds check and frame store access.
module lde_pixel_unit #(
  parameter int STORE_PIXELS = lde_pkg::STORE_PIXELS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lde_pkg::pix_req_t           req,
  input  logic [lde_pkg::COLOR_W-1:0] color,
  input  logic [lde_pkg::DIM_W-1:0]   row_width,
  input  logic [lde_pkg::DIM_W-1:0]   row_count,
  output lde_pkg::pu_stat_t           stat
);

  localparam int AW  = $clog2(STORE_PIXELS);
  localparam int AD  = lde_pkg::ADDR_W;
  localparam int CW  = lde_pkg::COORD_W;
  localparam int CLW = lde_pkg::COLOR_W;

  logic            valid1_r, valid2_r, valid3_r, rd_pend_r, rd_ok_r;
  logic            wr1_r, wr2_r, wr3_r;
  logic [CW-1:0]   x1_r, y1_r, x2_r;
  logic [AD-1:0]   prod_r, addr3_r, lim_r;
  logic [CLW-1:0]  value_r, ram_rdata;
  logic            addr_ok, ram_we, ram_re;

  // Track the pixel count limit of the current image shape
  always_ff @(posedge clk) begin
    lim_r <= AD'(row_width) * AD'(row_count);
  end

  // Stage valids and read tracking
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid1_r  <= 1'b0;
      valid2_r  <= 1'b0;
      valid3_r  <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      valid1_r  <= req.valid;
      valid2_r  <= valid1_r;
      valid3_r  <= valid2_r;
      rd_pend_r <= valid3_r && !wr3_r;
    end
  end

  // Row product, then address sum, then store access
  always_ff @(posedge clk) begin
    wr1_r   <= req.wr;
    x1_r    <= req.x;
    y1_r    <= req.y;
    wr2_r   <= wr1_r;
    x2_r    <= x1_r;
    prod_r  <= AD'(y1_r) * AD'(row_width);
    wr3_r   <= wr2_r;
    addr3_r <= prod_r + AD'(x2_r);
    rd_ok_r <= addr_ok;
    if (rd_pend_r) begin
      value_r <= rd_ok_r ? ram_rdata : '0;
    end
  end

  // Drop accesses outside the image or the store
  assign addr_ok = (addr3_r < lim_r) && (addr3_r < AD'(STORE_PIXELS));
  assign ram_we  = valid3_r && wr3_r && addr_ok;
  assign ram_re  = valid3_r && !wr3_r && addr_ok;

  lde_ram #(
    .WIDTH (CLW),
    .DEPTH (STORE_PIXELS)
  ) u_frame_store (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (addr3_r[AW-1:0]),
    .wdata (color),
    .rdata (ram_rdata)
  );

  assign stat.busy     = valid1_r || valid2_r || valid3_r || rd_pend_r;
  assign stat.rd_value = value_r;

endmodule

// ===== sv/line_draw_engine.sv =====
// Line draw engine top level: command sequencer, configuration registers, checks.
// A rejected command answers in the cycle after it is accepted; a pixel command runs
// via S_PIX, the pixel unit pipeline and S_DRAIN; a line via the stepper, then S_DRAIN.
// Throughput: one command at a time; a line writes one pixel per cycle through the
// single frame store port, so the stepper and that port set the rate.
// Reset (synchronous, rst_n low): sequencer idle, last endpoint (0,0), row_width and
// row_count 64; frame store contents are not cleared. Results cannot be stalled.
module line_draw_engine #(
  parameter int STORE_PIXELS = lde_pkg::STORE_PIXELS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // Command channel
  input  logic                       start,
  output logic                       busy,
  input  lde_pkg::cmd_t              in_cmd,
  // Result channel
  output logic                       out_valid,
  output lde_pkg::result_t           out_result,
  // Configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [lde_pkg::CFG_AW-1:0] paddr,
  input  logic [lde_pkg::CFG_DW-1:0] pwdata,
  output logic [lde_pkg::CFG_DW-1:0] prdata,
  output logic                       pready
);

  localparam int CW  = lde_pkg::COORD_W;
  localparam int DW  = lde_pkg::DIM_W;
  localparam int CLW = lde_pkg::COLOR_W;

  typedef enum logic [1:0] {S_IDLE, S_PIX, S_LINE, S_DRAIN} state_t;

  state_t             state_r, state_nxt;
  logic               out_valid_r, out_valid_nxt;
  lde_pkg::result_t   out_result_r, out_result_nxt;
  logic [CW-1:0]      last_x_r, last_x_nxt, last_y_r, last_y_nxt;
  logic [CW-1:0]      px_r, px_nxt, py_r, py_nxt;
  lde_pkg::mode_t     mode_r, mode_nxt;
  logic [CLW-1:0]     color_r, color_nxt;
  logic [DW-1:0]      row_width_r, row_count_r;

  logic               accept, cfg_wr, is_line, start_ok, end_ok, reject, step_load;
  logic [CW-1:0]      sx, sy;
  lde_pkg::line_t     pts;
  lde_pkg::step_out_t step_out;
  lde_pkg::pix_req_t  cmd_req, req;
  lde_pkg::pu_stat_t  pu_stat;

  // Configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r <= lde_pkg::ROW_WIDTH_RST;
      row_count_r <= lde_pkg::ROW_COUNT_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == lde_pkg::REG_ROW_WIDTH) begin
        row_width_r <= pwdata[DW-1:0];
      end else begin
        row_count_r <= pwdata[DW-1:0];
      end
    end
  end

  assign prdata = (paddr[2] == lde_pkg::REG_ROW_COUNT) ?
                  {{(lde_pkg::CFG_DW-DW){1'b0}}, row_count_r} :
                  {{(lde_pkg::CFG_DW-DW){1'b0}}, row_width_r};

  // Command acceptance and bounds check
  assign busy    = (state_r != S_IDLE);
  assign accept  = start && !busy;
  assign is_line = (in_cmd.mode == lde_pkg::MODE_LINE) ||
                   (in_cmd.mode == lde_pkg::MODE_POLY);
  assign sx      = (in_cmd.mode == lde_pkg::MODE_POLY) ? last_x_r : in_cmd.x_start;
  assign sy      = (in_cmd.mode == lde_pkg::MODE_POLY) ? last_y_r : in_cmd.y_start;
  assign start_ok = ({1'b0, sx} <= row_width_r) && ({1'b0, sy} <= row_count_r);
  assign end_ok   = ({1'b0, in_cmd.x_end} <= row_width_r) &&
                    ({1'b0, in_cmd.y_end} <= row_count_r);
  assign reject   = !start_ok || (is_line && !end_ok);

  assign pts.x0 = sx;
  assign pts.y0 = sy;
  assign pts.x1 = in_cmd.x_end;
  assign pts.y1 = in_cmd.y_end;

  // Sequencer next state
  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = 1'b0;
    out_result_nxt = out_result_r;
    last_x_nxt     = last_x_r;
    last_y_nxt     = last_y_r;
    px_nxt         = px_r;
    py_nxt         = py_r;
    mode_nxt       = mode_r;
    color_nxt      = color_r;
    step_load      = 1'b0;
    cmd_req        = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          mode_nxt  = in_cmd.mode;
          color_nxt = in_cmd.color;
          px_nxt    = in_cmd.x_start;
          py_nxt    = in_cmd.y_start;
          if (reject) begin
            out_valid_nxt              = 1'b1;
            out_result_nxt.status      = lde_pkg::STATUS_REJECT;
            out_result_nxt.pixel_value = '0;
          end else if (is_line) begin
            step_load  = 1'b1;
            last_x_nxt = in_cmd.x_end;
            last_y_nxt = in_cmd.y_end;
            state_nxt  = S_LINE;
          end else begin
            state_nxt  = S_PIX;
          end
        end
      end
      S_PIX: begin
        cmd_req.valid = 1'b1;
        cmd_req.wr    = (mode_r == lde_pkg::MODE_WRITE);
        cmd_req.x     = px_r;
        cmd_req.y     = py_r;
        state_nxt     = S_DRAIN;
      end
      S_LINE: begin
        if (!step_out.active) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pu_stat.busy) begin
          out_valid_nxt              = 1'b1;
          out_result_nxt.status      = lde_pkg::STATUS_DONE;
          out_result_nxt.pixel_value = (mode_r == lde_pkg::MODE_READ) ?
                                       pu_stat.rd_value : '0;
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state, endpoint and the result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      last_x_r    <= '0;
      last_y_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      last_x_r    <= last_x_nxt;
      last_y_r    <= last_y_nxt;
    end
    out_result_r <= out_result_nxt;
    px_r         <= px_nxt;
    py_r         <= py_nxt;
    mode_r       <= mode_nxt;
    color_r      <= color_nxt;
  end

  assign out_valid  = out_valid_r;
  assign out_result = out_result_r;

  lde_stepper u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (step_load),
    .pts      (pts),
    .step_out (step_out)
  );

  // Merge stepper pixels with single pixel commands
  always_comb begin
    req = cmd_req;
    if (step_out.valid) begin
      req.valid = 1'b1;
      req.wr    = 1'b1;
      req.x     = step_out.x;
      req.y     = step_out.y;
    end
  end

  lde_pixel_unit #(
    .STORE_PIXELS (STORE_PIXELS)
  ) u_pixel_unit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .color     (color_r),
    .row_width (row_width_r),
    .row_count (row_count_r),
    .stat      (pu_stat)
  );

`ifndef SYNTHESIS
  // A result is only presented once the sequencer is idle again
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result presented while busy");

  // Every accepted transaction keeps the block busy or answers at once
  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (busy || out_valid))
    else $error("accepted transaction neither busy nor answered");

  // Stepper pixels only while a line is in progress
  a_step_in_line: assert property (@(posedge clk) disable iff (!rst_n)
    step_out.valid |-> (state_r == S_LINE))
    else $error("stepper pixel outside line drawing");

  // Pixel pipeline drained whenever the sequencer is idle
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pu_stat.busy)
    else $error("pixel pipeline busy while idle");
`endif

endmodule
